FILE: hw/rtl/tarl_pkg.sv
package tarl_pkg;

  // Result status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DEPTH    = 3'd1;
  localparam logic [2:0] ST_NO_TRI   = 3'd2;
  localparam logic [2:0] ST_NEG_DISC = 3'd3;
  localparam logic [2:0] ST_NO_POS   = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_SONAR_DX = 1'b0;
  localparam logic CFG_SONAR_DY = 1'b1;

  // Operation codes of the iterative root and divide unit.
  localparam logic [1:0] ITU_SQ32 = 2'd0;  // root of a 32-bit value
  localparam logic [1:0] ITU_SQ66 = 2'd1;  // root of a 66-bit value
  localparam logic [1:0] ITU_DIVS = 2'd2;  // signed divide, quotient below 2^18
  localparam logic [1:0] ITU_DIVF = 2'd3;  // signed divide, dividend below 2^36

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [15:0] slant_a;
    logic [15:0] slant_b;
    logic [15:0] depth;
    logic        depth_fail;
  } tarl_item_t;

endpackage

FILE: hw/rtl/tarl_front.sv
module tarl_front #(
  parameter int RANGE_BITS = 16
) (
  input  logic                  start,
  input  logic                  queue_full,
  input  logic [15:0]           in_slant_range_a,
  input  logic [15:0]           in_slant_range_b,
  input  logic [15:0]           in_depth_mm,
  output logic                  push,
  output tarl_pkg::tarl_item_t  item
);

  localparam logic [15:0] IN_MASK =
    (RANGE_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << RANGE_BITS) - 32'd1);

  logic [15:0] a_m, b_m, d_m;

  // Ranges are limited to the configured width before any arithmetic.
  assign a_m = in_slant_range_a & IN_MASK;
  assign b_m = in_slant_range_b & IN_MASK;
  assign d_m = in_depth_mm & IN_MASK;

  assign push = start && !queue_full;

  always_comb begin
    item.slant_a    = a_m;
    item.slant_b    = b_m;
    item.depth      = d_m;
    item.depth_fail = (d_m >= a_m) || (d_m >= b_m);
  end

endmodule

FILE: hw/rtl/tarl_queue.sv
module tarl_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  tarl_pkg::tarl_item_t  push_item,
  input  logic                  pop,
  output logic                  full,
  output logic                  not_empty,
  output tarl_pkg::tarl_item_t  head
);

  localparam int PW = (tarl_pkg::QUEUE_DEPTH > 1) ? $clog2(tarl_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(tarl_pkg::QUEUE_DEPTH + 1);

  tarl_pkg::tarl_item_t entry_r [tarl_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full      = (count_r == CW'(tarl_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        entry_r[wr_ptr_r] <= push_item;
        wr_ptr_r <= (wr_ptr_r == PW'(tarl_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(tarl_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/tarl_itu.sv
module tarl_itu (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [1:0]         mode,
  input  logic [65:0]        opd,
  input  logic signed [51:0] num,
  input  logic [32:0]        den,
  output logic               done,
  output logic signed [36:0] res
);

  logic        busy_r, done_r, sq_r, neg_r;
  logic [5:0]  cnt_r;
  logic [37:0] rem_r;
  logic [35:0] q_r;
  logic [65:0] work_r;
  logic [32:0] den_r;

  logic [51:0] mag;
  logic [37:0] ld_rem;
  logic [65:0] ld_work;
  logic [5:0]  ld_cnt;
  logic        ld_sq;
  logic [37:0] rs, tr, rem_nxt;
  logic        ge;

  assign mag = num[51] ? 52'(-num) : 52'(num);

  always_comb begin
    ld_rem  = '0;
    ld_work = {opd[31:0], 34'd0};
    ld_cnt  = 6'd16;
    ld_sq   = 1'b1;
    case (mode)
      tarl_pkg::ITU_SQ32: begin
        ld_work = {opd[31:0], 34'd0};
        ld_cnt  = 6'd16;
      end
      tarl_pkg::ITU_SQ66: begin
        ld_work = opd;
        ld_cnt  = 6'd33;
      end
      tarl_pkg::ITU_DIVS: begin
        // The quotient is known to stay below 2^18, so the upper dividend
        // bits start out already as partial remainder.
        ld_rem  = {4'd0, mag[51:18]};
        ld_work = {mag[17:0], 48'd0};
        ld_cnt  = 6'd18;
        ld_sq   = 1'b0;
      end
      tarl_pkg::ITU_DIVF: begin
        ld_work = {mag[35:0], 30'd0};
        ld_cnt  = 6'd36;
        ld_sq   = 1'b0;
      end
      default: begin
        ld_work = {opd[31:0], 34'd0};
      end
    endcase
  end

  // One result bit per cycle: restoring divide or digit-by-digit root.
  always_comb begin
    rs      = sq_r ? {rem_r[35:0], work_r[65:64]} : {rem_r[36:0], work_r[65]};
    tr      = sq_r ? {q_r, 2'b01} : {5'd0, den_r};
    ge      = (rs >= tr);
    rem_nxt = ge ? rs - tr : rs;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        sq_r   <= ld_sq;
        neg_r  <= !ld_sq && num[51];
        cnt_r  <= ld_cnt;
        rem_r  <= ld_rem;
        q_r    <= '0;
        work_r <= ld_work;
        den_r  <= den;
      end else if (busy_r) begin
        rem_r  <= rem_nxt;
        q_r    <= {q_r[34:0], ge};
        work_r <= sq_r ? {work_r[63:0], 2'b00} : {work_r[64:0], 1'b0};
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign res  = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});

endmodule

FILE: hw/rtl/tarl_back.sv
module tarl_back #(
  parameter int RANGE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic signed [15:0]    sonar_dx,
  input  logic [14:0]           sonar_dy,
  input  logic                  q_valid,
  input  tarl_pkg::tarl_item_t  q_item,
  output logic                  q_pop,
  output logic                  out_valid,
  output logic [15:0]           out_pos_x,
  output logic [15:0]           out_pos_y,
  output logic [2:0]            out_status,
  output logic                  out_ambiguous
);

  localparam logic [4:0] S_IDLE = 5'd0,  S_AA  = 5'd1,  S_DD  = 5'd2,  S_BB  = 5'd3,
                         S_XX   = 5'd4,  S_YY  = 5'd5,  S_SQA = 5'd6,  S_WA  = 5'd7,
                         S_WB   = 5'd8,  S_WD  = 5'd9,  S_TRI = 5'd10, S_NN  = 5'd11,
                         S_CMP  = 5'd12, S_WS  = 5'd13, S_NDX = 5'd14, S_DYS = 5'd15,
                         S_X1   = 5'd16, S_WX1 = 5'd17, S_WX2 = 5'd18, S_M1  = 5'd19,
                         S_M2   = 5'd20, S_WY1 = 5'd21, S_WY2 = 5'd22;

  localparam logic signed [36:0] SAT_MAX = 37'((64'd1 << RANGE_BITS) - 64'd1);

  function automatic logic [15:0] sat_pos(input logic signed [36:0] v);
    logic signed [36:0] c;
    c = (v > SAT_MAX) ? SAT_MAX : v;
    return c[15:0];
  endfunction

  logic [4:0] state_r, state_nxt;

  logic                mul_en;
  logic signed [34:0]  ma, mb;
  logic signed [69:0]  prod_r;

  logic                itu_start, itu_done;
  logic [1:0]          itu_mode;
  logic [65:0]         itu_opd;
  logic signed [51:0]  itu_num;
  logic [32:0]         itu_den;
  logic signed [36:0]  itu_res;

  logic [15:0]         a_r, b_r, d_r, ra_r, rb_r, ds_r;
  logic [31:0]         dd_r, ra2_r, rb2_r;
  logic [30:0]         dsq_r;
  logic signed [34:0]  n_r;
  logic [65:0]         f_r;
  logic [32:0]         s_r;
  logic signed [51:0]  t1_r, dys_r;
  logic signed [19:0]  x1_r, x2_r;
  logic signed [36:0]  y1_r;

  logic                out_valid_r, out_amb_r;
  logic [15:0]         out_x_r, out_y_r;
  logic [2:0]          out_st_r;

  logic [14:0]         dy_eff;
  logic signed [34:0]  n_abs, n_calc;
  logic [67:0]         nn;
  logic [16:0]         r_sum;
  logic [15:0]         r_diff;
  logic                tri_fail, v1, v2;

  // A zero baseline y offset is read as one millimetre.
  assign dy_eff = (sonar_dy == '0) ? 15'd1 : sonar_dy;
  assign n_abs  = n_r[34] ? -n_r : n_r;
  assign n_calc = $signed({3'd0, ra2_r}) - $signed({3'd0, rb2_r}) + $signed({4'd0, dsq_r});
  assign nn     = prod_r[67:0];
  assign r_sum  = {1'b0, ra_r} + {1'b0, rb_r};
  assign r_diff = (ra_r > rb_r) ? ra_r - rb_r : rb_r - ra_r;
  assign tri_fail = (r_sum < {1'b0, ds_r}) || (r_diff > ds_r);
  assign v1 = (x1_r > 20'sd0) && (y1_r > 37'sd0);
  assign v2 = (x2_r > 20'sd0) && (itu_res > 37'sd0);

  tarl_itu u_itu (
    .clk   (clk),
    .rst_n (rst_n),
    .start (itu_start),
    .mode  (itu_mode),
    .opd   (itu_opd),
    .num   (itu_num),
    .den   (itu_den),
    .done  (itu_done),
    .res   (itu_res)
  );

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    mul_en    = 1'b0;
    ma        = '0;
    mb        = '0;
    itu_start = 1'b0;
    itu_mode  = tarl_pkg::ITU_SQ32;
    itu_opd   = '0;
    itu_num   = '0;
    itu_den   = '0;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (!q_item.depth_fail) begin
            state_nxt = S_AA;
          end
        end
      end
      S_AA: begin
        mul_en = 1'b1;
        ma = $signed({19'd0, a_r});
        mb = $signed({19'd0, a_r});
        state_nxt = S_DD;
      end
      S_DD: begin
        mul_en = 1'b1;
        ma = $signed({19'd0, d_r});
        mb = $signed({19'd0, d_r});
        state_nxt = S_BB;
      end
      S_BB: begin
        mul_en = 1'b1;
        ma = $signed({19'd0, b_r});
        mb = $signed({19'd0, b_r});
        state_nxt = S_XX;
      end
      S_XX: begin
        mul_en = 1'b1;
        ma = 35'(sonar_dx);
        mb = 35'(sonar_dx);
        state_nxt = S_YY;
      end
      S_YY: begin
        mul_en = 1'b1;
        ma = $signed({20'd0, dy_eff});
        mb = $signed({20'd0, dy_eff});
        state_nxt = S_SQA;
      end
      S_SQA: begin
        itu_start = 1'b1;
        itu_mode  = tarl_pkg::ITU_SQ32;
        itu_opd   = {34'd0, ra2_r};
        state_nxt = S_WA;
      end
      S_WA: begin
        if (itu_done) begin
          itu_start = 1'b1;
          itu_mode  = tarl_pkg::ITU_SQ32;
          itu_opd   = {34'd0, rb2_r};
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        if (itu_done) begin
          itu_start = 1'b1;
          itu_mode  = tarl_pkg::ITU_SQ32;
          itu_opd   = {35'd0, dsq_r};
          state_nxt = S_WD;
        end
      end
      S_WD: begin
        if (itu_done) begin
          state_nxt = S_TRI;
        end
      end
      S_TRI: begin
        if (tri_fail) begin
          state_nxt = S_IDLE;
        end else begin
          mul_en = 1'b1;
          ma = $signed({4'd0, dsq_r});
          mb = $signed({3'd0, ra2_r});
          state_nxt = S_NN;
        end
      end
      S_NN: begin
        mul_en = 1'b1;
        ma = n_abs;
        mb = n_abs;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (nn > {2'd0, f_r}) begin
          state_nxt = S_IDLE;
        end else begin
          itu_start = 1'b1;
          itu_mode  = tarl_pkg::ITU_SQ66;
          itu_opd   = f_r - nn[65:0];
          state_nxt = S_WS;
        end
      end
      S_WS: begin
        if (itu_done) begin
          state_nxt = S_NDX;
        end
      end
      S_NDX: begin
        mul_en = 1'b1;
        ma = n_r;
        mb = 35'(sonar_dx);
        state_nxt = S_DYS;
      end
      S_DYS: begin
        mul_en = 1'b1;
        ma = $signed({20'd0, dy_eff});
        mb = $signed({2'd0, s_r});
        state_nxt = S_X1;
      end
      S_X1: begin
        itu_start = 1'b1;
        itu_mode  = tarl_pkg::ITU_DIVS;
        itu_num   = t1_r + prod_r[51:0];
        itu_den   = {1'b0, dsq_r, 1'b0};
        state_nxt = S_WX1;
      end
      S_WX1: begin
        if (itu_done) begin
          itu_start = 1'b1;
          itu_mode  = tarl_pkg::ITU_DIVS;
          itu_num   = t1_r - dys_r;
          itu_den   = {1'b0, dsq_r, 1'b0};
          state_nxt = S_WX2;
        end
      end
      S_WX2: begin
        if (itu_done) begin
          state_nxt = S_M1;
        end
      end
      S_M1: begin
        mul_en = 1'b1;
        ma = 35'(x1_r);
        mb = 35'(sonar_dx);
        state_nxt = S_M2;
      end
      S_M2: begin
        itu_start = 1'b1;
        itu_mode  = tarl_pkg::ITU_DIVF;
        itu_num   = 52'(n_r) - {prod_r[50:0], 1'b0};
        itu_den   = {17'd0, dy_eff, 1'b0};
        mul_en = 1'b1;
        ma = 35'(x2_r);
        mb = 35'(sonar_dx);
        state_nxt = S_WY1;
      end
      S_WY1: begin
        if (itu_done) begin
          itu_start = 1'b1;
          itu_mode  = tarl_pkg::ITU_DIVF;
          itu_num   = 52'(n_r) - {prod_r[50:0], 1'b0};
          itu_den   = {17'd0, dy_eff, 1'b0};
          state_nxt = S_WY2;
        end
      end
      S_WY2: begin
        if (itu_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= ma * mb;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            a_r <= q_item.slant_a;
            b_r <= q_item.slant_b;
            d_r <= q_item.depth;
            if (q_item.depth_fail) begin
              out_valid_r <= 1'b1;
              out_x_r     <= '0;
              out_y_r     <= '0;
              out_st_r    <= tarl_pkg::ST_DEPTH;
              out_amb_r   <= 1'b0;
            end
          end
        end
        S_DD:  ra2_r <= prod_r[31:0];
        S_BB: begin
          dd_r  <= prod_r[31:0];
          ra2_r <= ra2_r - prod_r[31:0];
        end
        S_XX:  rb2_r <= prod_r[31:0] - dd_r;
        S_YY:  dsq_r <= prod_r[30:0];
        S_SQA: dsq_r <= dsq_r + prod_r[30:0];
        S_WA:  if (itu_done) ra_r <= itu_res[15:0];
        S_WB:  if (itu_done) rb_r <= itu_res[15:0];
        S_WD:  if (itu_done) ds_r <= itu_res[15:0];
        S_TRI: begin
          n_r <= n_calc;
          if (tri_fail) begin
            out_valid_r <= 1'b1;
            out_x_r     <= '0;
            out_y_r     <= '0;
            out_st_r    <= tarl_pkg::ST_NO_TRI;
            out_amb_r   <= 1'b0;
          end
        end
        S_NN:  f_r <= {prod_r[63:0], 2'b00};
        S_CMP: begin
          if (nn > {2'd0, f_r}) begin
            out_valid_r <= 1'b1;
            out_x_r     <= '0;
            out_y_r     <= '0;
            out_st_r    <= tarl_pkg::ST_NEG_DISC;
            out_amb_r   <= 1'b0;
          end
        end
        S_WS:  if (itu_done) s_r <= itu_res[32:0];
        S_DYS: t1_r <= prod_r[51:0];
        S_X1:  dys_r <= prod_r[51:0];
        S_WX1: if (itu_done) x1_r <= itu_res[19:0];
        S_WX2: if (itu_done) x2_r <= itu_res[19:0];
        S_WY1: if (itu_done) y1_r <= itu_res;
        S_WY2: begin
          if (itu_done) begin
            out_valid_r <= 1'b1;
            out_amb_r   <= 1'b0;
            out_st_r    <= tarl_pkg::ST_OK;
            if (v1) begin
              out_x_r   <= sat_pos(37'(x1_r));
              out_y_r   <= sat_pos(y1_r);
              out_amb_r <= v2;
            end else if (v2) begin
              out_x_r <= sat_pos(37'(x2_r));
              out_y_r <= sat_pos(itu_res);
            end else begin
              out_x_r  <= '0;
              out_y_r  <= '0;
              out_st_r <= tarl_pkg::ST_NO_POS;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pos_x     = out_x_r;
  assign out_pos_y     = out_y_r;
  assign out_status    = out_st_r;
  assign out_ambiguous = out_amb_r;

endmodule

FILE: hw/rtl/two_anchor_range_localizer_top.sv
// Two-anchor range localizer. An item (two slant ranges and a depth, in
// millimetres) is transferred at a clock edge where start is high and busy
// is low; a two-entry queue lets a new item be taken while an earlier one is
// still being solved. Each item produces exactly one result, shown on the
// out_ ports for a single cycle with out_valid high; the receiver cannot
// stall, so it must capture every result in that cycle. A full solution
// runs on the shared iterative unit, which produces one root or quotient
// bit per cycle (four square roots and four divisions). An item that fails
// the depth check is retired without arithmetic, and one that fails the
// triangle check or has a negative discriminant ends early. Configuration
// writes on the cfg_ port take effect at once and should only be made
// while no transfer is outstanding.
module two_anchor_range_localizer_top #(
  parameter int RANGE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_slant_range_a,
  input  logic [15:0] in_slant_range_b,
  input  logic [15:0] in_depth_mm,
  output logic        out_valid,
  output logic [15:0] out_pos_x,
  output logic [15:0] out_pos_y,
  output logic [2:0]  out_status,
  output logic        out_ambiguous,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  // Baseline registers: anchor B relative to anchor A.
  logic signed [15:0] sonar_dx_r;
  logic [14:0]        sonar_dy_r;

  logic                 push, pop, queue_full, queue_not_empty;
  tarl_pkg::tarl_item_t push_item, head_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sonar_dx_r <= 16'sd260;
      sonar_dy_r <= 15'd212;
    end else if (cfg_we) begin
      case (cfg_index)
        tarl_pkg::CFG_SONAR_DX: sonar_dx_r <= cfg_wdata;
        tarl_pkg::CFG_SONAR_DY: sonar_dy_r <= cfg_wdata[14:0];
        default: begin
        end
      endcase
    end
  end

  // The front end masks the ranges and flags items whose depth is not below
  // both slant ranges, so the back end can retire them without arithmetic.
  tarl_front #(.RANGE_BITS(RANGE_BITS)) u_front (
    .start            (start),
    .queue_full       (queue_full),
    .in_slant_range_a (in_slant_range_a),
    .in_slant_range_b (in_slant_range_b),
    .in_depth_mm      (in_depth_mm),
    .push             (push),
    .item             (push_item)
  );

  tarl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (queue_full),
    .not_empty (queue_not_empty),
    .head      (head_item)
  );

  // The back end sequences one shared multiplier and the iterative root and
  // divide unit through the circle intersection.
  tarl_back #(.RANGE_BITS(RANGE_BITS)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .sonar_dx      (sonar_dx_r),
    .sonar_dy      (sonar_dy_r),
    .q_valid       (queue_not_empty),
    .q_item        (head_item),
    .q_pop         (pop),
    .out_valid     (out_valid),
    .out_pos_x     (out_pos_x),
    .out_pos_y     (out_pos_y),
    .out_status    (out_status),
    .out_ambiguous (out_ambiguous)
  );

  assign busy = queue_full;

endmodule

FILE: hw/rtl/tarl_checker.sv
module tarl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [15:0] out_pos_x,
  input logic [15:0] out_pos_y,
  input logic [2:0]  out_status,
  input logic        out_ambiguous
);

  // A failed item always reports a zero position and no ambiguity.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != tarl_pkg::ST_OK |->
      out_pos_x == 16'd0 && out_pos_y == 16'd0 && !out_ambiguous)
    else $error("failed result carries a position");

  a_amb_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ambiguous |-> out_status == tarl_pkg::ST_OK)
    else $error("ambiguity flagged on a failed result");

  // The queue can only fill up right after a transfer.
  a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a transfer");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("outputs active after reset");

endmodule

bind two_anchor_range_localizer_top tarl_checker u_tarl_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_pos_x     (out_pos_x),
  .out_pos_y     (out_pos_y),
  .out_status    (out_status),
  .out_ambiguous (out_ambiguous)
);

FILE: test/two_anchor_range_localizer_top_tb.sv
module two_anchor_range_localizer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Expected position fixes, predicted from the anchor geometry and the
  // ranges of each accepted transfer, and checked in order of arrival.
  class fix_scoreboard;
    typedef struct {
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [2:0]  status;
      logic        ambiguous;
    } fix_t;

    fix_t             pending_fixes[$];
    logic signed [15:0] base_dx = 16'sd260;
    logic [14:0]        base_dy = 15'd212;
    int               mismatches = 0;

    static function longint unsigned int_sqrt(logic [127:0] v);
      logic [63:0]  r;
      logic [63:0]  t;
      logic [127:0] sq;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
        t = r | (64'd1 << i);
        sq = 128'(t) * 128'(t);
        if (sq <= v) r = t;
      end
      return r;
    endfunction

    function void set_reg(logic idx, logic [15:0] val);
      if (idx == tarl_pkg::CFG_SONAR_DX) base_dx = val;
      else base_dy = val[14:0];
    endfunction

    function longint unsigned clip(longint v);
      return (v > 65535) ? 65535 : v;
    endfunction

    function void note_input(logic [15:0] a, logic [15:0] b, logic [15:0] d);
      fix_t f;
      longint unsigned ra2, rb2, ra, rb, dsq, ds, diff, nabs;
      longint n, s, den, x1, x2, y1, y2, dxl, dyl;
      logic [127:0] four_d_ra2, nsq;
      f = '{16'd0, 16'd0, tarl_pkg::ST_OK, 1'b0};
      dxl = longint'(base_dx);
      dyl = (base_dy == 0) ? 1 : longint'(base_dy);
      if (d >= a || d >= b) begin
        f.status = tarl_pkg::ST_DEPTH;
      end else begin
        ra2 = 64'(a) * 64'(a) - 64'(d) * 64'(d);
        rb2 = 64'(b) * 64'(b) - 64'(d) * 64'(d);
        ra = int_sqrt(128'(ra2));
        rb = int_sqrt(128'(rb2));
        dsq = dxl * dxl + dyl * dyl;
        ds = int_sqrt(128'(dsq));
        diff = (ra > rb) ? ra - rb : rb - ra;
        if (ra + rb < ds || diff > ds) begin
          f.status = tarl_pkg::ST_NO_TRI;
        end else begin
          n = longint'(ra2) - longint'(rb2) + longint'(dsq);
          nabs = (n < 0) ? -n : n;
          four_d_ra2 = (128'(dsq) * 128'(ra2)) << 2;
          nsq = 128'(nabs) * 128'(nabs);
          if (nsq > four_d_ra2) begin
            f.status = tarl_pkg::ST_NEG_DISC;
          end else begin
            s = int_sqrt(four_d_ra2 - nsq);
            den = 2 * longint'(dsq);
            x1 = (n * dxl + dyl * s) / den;
            x2 = (n * dxl - dyl * s) / den;
            y1 = (n - 2 * x1 * dxl) / (2 * dyl);
            y2 = (n - 2 * x2 * dxl) / (2 * dyl);
            if (x1 > 0 && y1 > 0) begin
              f.pos_x = 16'(clip(x1));
              f.pos_y = 16'(clip(y1));
              f.ambiguous = (x2 > 0 && y2 > 0);
            end else if (x2 > 0 && y2 > 0) begin
              f.pos_x = 16'(clip(x2));
              f.pos_y = 16'(clip(y2));
            end else begin
              f.status = tarl_pkg::ST_NO_POS;
            end
          end
        end
      end
      pending_fixes.push_back(f);
    endfunction

    function void check_result(logic [15:0] x, logic [15:0] y, logic [2:0] st, logic amb);
      fix_t e;
      if (pending_fixes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result x=%0d y=%0d status=%0d", x, y, st);
        return;
      end
      e = pending_fixes.pop_front();
      if (x !== e.pos_x || y !== e.pos_y || st !== e.status || amb !== e.ambiguous) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected x=%0d y=%0d status=%0d amb=%0d, ",
                    "got x=%0d y=%0d status=%0d amb=%0d"},
                   e.pos_x, e.pos_y, e.status, e.ambiguous, x, y, st, amb);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] in_slant_range_a = '0;
  logic [15:0] in_slant_range_b = '0;
  logic [15:0] in_depth_mm = '0;
  logic        out_valid;
  logic [15:0] out_pos_x;
  logic [15:0] out_pos_y;
  logic [2:0]  out_status;
  logic        out_ambiguous;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_wdata = '0;

  fix_scoreboard fixes = new();
  // When set, the sender never idles between items, so transfers go back to back.
  bit back_to_back = 0;

  two_anchor_range_localizer_top u_dut (.*);

  always #5 clk = ~clk;

  // Every result is on the bus for exactly one cycle, so it is captured at the edge
  // that ends that cycle, with no way to hold it off.
  always @(posedge clk) begin
    if (rst_n && out_valid) fixes.check_result(out_pos_x, out_pos_y, out_status, out_ambiguous);
  end

  // The watchdog restarts whenever a transfer happens on either side. The queue
  // holds two items, so a watchdog that runs out means the block has hung.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 5000) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Drives one range set. The strobe is left high after the transfer, so that a
  // following item with no gap keeps it high without a glitch.
  task automatic send_ranges(logic [15:0] a, logic [15:0] b, logic [15:0] d);
    int gap;
    gap = back_to_back ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_slant_range_a = a;
    in_slant_range_b = b;
    in_depth_mm = d;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    fixes.note_input(a, b, d);
    @(negedge clk);
  endtask

  // Register writes are only made when no fix is outstanding. Every item yields a
  // result, so an empty scoreboard means the block is idle.
  task automatic write_reg(logic idx, logic [15:0] val);
    start = 1'b0;
    while (fixes.pending_fixes.size() != 0) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    fixes.set_reg(idx, val);
  endtask

  // Builds consistent ranges from a real point in the positive quadrant, with a
  // millimetre of jitter so that truncation edges are also exercised.
  task automatic send_solvable();
    longint x, y, d, ex, ey, dyl;
    longint unsigned a, b;
    x = $urandom_range(1, 15000);
    y = $urandom_range(1, 15000);
    d = $urandom_range(0, 15000);
    dyl = (fixes.base_dy == 0) ? 1 : longint'(fixes.base_dy);
    ex = x - longint'(fixes.base_dx);
    ey = y - dyl;
    a = fix_scoreboard::int_sqrt(128'(x * x + y * y + d * d)) + $urandom_range(0, 1);
    b = fix_scoreboard::int_sqrt(128'(ex * ex + ey * ey + d * d)) + $urandom_range(0, 1);
    if (a > 65535) a = 65535;
    if (b > 65535) b = 65535;
    send_ranges(16'(a), 16'(b), 16'(d));
  endtask

  logic [15:0] phase_dx[6] = '{16'd260, 16'd32767, -16'sd32767, 16'd0, -16'sd5, 16'd1200};
  logic [15:0] phase_dy[6] = '{16'd212, 16'd32767, 16'd1, 16'd0, 16'h812c, 16'd900};

  initial begin
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Directed cases under the reset baseline: depth failures at the field
    // extremes, no triangle in both directions, a negative discriminant right at
    // the triangle edge, a point behind the anchors, and consistent fixes.
    send_ranges(16'd0, 16'd0, 16'd0);
    send_ranges(16'd65535, 16'd65535, 16'd65535);
    send_ranges(16'd65535, 16'd65535, 16'd0);
    send_ranges(16'd100, 16'd200, 16'd200);
    send_ranges(16'd300, 16'd100, 16'd100);
    send_ranges(16'd100, 16'd100, 16'd0);
    send_ranges(16'd1000, 16'd50, 16'd0);
    send_ranges(16'd167, 16'd168, 16'd0);
    send_ranges(16'd168, 16'd168, 16'd0);
    send_ranges(16'd141, 16'd476, 16'd0);
    send_ranges(16'd500, 16'd400, 16'd300);
    send_ranges(16'd65535, 16'd65500, 16'd1);
    repeat (8) send_solvable();

    for (int p = 0; p < 6; p++) begin
      write_reg(tarl_pkg::CFG_SONAR_DX, phase_dx[p]);
      write_reg(tarl_pkg::CFG_SONAR_DY, phase_dy[p]);
      back_to_back = (p % 3 == 2);
      for (int i = 0; i < 63; i++) begin
        if ($urandom_range(0, 9) < 7) send_solvable();
        else send_ranges(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                         16'($urandom_range(0, 65535)));
      end
    end

    start = 1'b0;
    while (fixes.pending_fixes.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fixes.mismatches == 0 && fixes.pending_fixes.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
